// ===== hw/rtl/te_pkg.sv =====
`default_nettype none

package te_pkg;

  localparam int CH_W     = 3;
  localparam int CFG_AW   = 4;
  localparam int ENV_W    = 32;
  localparam int RATIO_W  = 16;
  localparam int DIVCNT_W = 4;
  localparam int ONE_Q16  = 65536;

  localparam logic [1:0] REG_FAST = 2'd0;
  localparam logic [1:0] REG_SLOW = 2'd1;
  localparam logic [1:0] REG_SENS = 2'd2;
  localparam logic [1:0] REG_GAIN = 2'd3;

  localparam logic [23:0]        FAST_COEF_RST = 24'd188090;
  localparam logic [23:0]        SLOW_COEF_RST = 24'd7605;
  localparam logic [19:0]        SENS_RST      = 20'd32768;
  localparam logic signed [20:0] GAIN_RST      = 21'sd0;

  localparam logic [ENV_W-1:0] ENV_FLOOR = 32'd214748;

  typedef struct packed {
    logic             start;
    logic [ENV_W-1:0] rem;
    logic [ENV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/transient_enhancer.sv =====
`default_nettype none

// From input word accept to out_tvalid: a channel out of range goes straight to the output
// step; a sample with no transient passes the envelope updates and the detection compare;
// when a transient is found, the 16-bit bit-serial ratio divider and the gain multiplies follow.
// One sample is in flight at a time; a new word is taken once the last result is loaded.
// Reset (synchronous, rst_n low): registers to defaults, envelope valid bits and count cleared.
module transient_enhancer #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // sample_in, channel_index
  input  wire logic [((SAMPLE_BITS+te_pkg::CH_W+7)/8)*8-1:0] in_tdata,
  // restart
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // sample_out, transient_count
  output logic [((SAMPLE_BITS+32+7)/8)*8-1:0] out_tdata,
  // enhanced
  output logic                        out_tuser,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [te_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int OUT_W  = ((SAMPLE_BITS + 32 + 7) / 8) * 8;
  localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PROD_W = 58;
  localparam int MEM_W  = 2 * te_pkg::ENV_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FMUL = 4'd1;
  localparam logic [3:0] S_FUPD = 4'd2;
  localparam logic [3:0] S_SMUL = 4'd3;
  localparam logic [3:0] S_SUPD = 4'd4;
  localparam logic [3:0] S_DMUL = 4'd5;
  localparam logic [3:0] S_DCMP = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_GMUL = 4'd8;
  localparam logic [3:0] S_GRND = 4'd9;
  localparam logic [3:0] S_YMUL = 4'd10;
  localparam logic [3:0] S_YRND = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic signed [PROD_W-1:0] LIM_HI = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] LIM_LO = -(PROD_W'(1) <<< (SAMPLE_BITS - 1));

  logic [23:0]        fast_coef_r;
  logic [23:0]        slow_coef_r;
  logic [19:0]        sens_r;
  logic signed [20:0] gain_m1_r;

  logic [3:0]                      state_r;
  logic signed [SAMPLE_BITS-1:0]   x_r;
  logic [AW-1:0]                   addr_r;
  logic                            ch_zero_r;
  logic                            env_ok_r;
  logic [MEM_W-1:0]                mem [MAX_CHANNELS];
  logic [MEM_W-1:0]                mem_q_r;
  logic [MAX_CHANNELS-1:0]         valid_r;
  logic [te_pkg::ENV_W-1:0]        f_r;
  logic [te_pkg::ENV_W-1:0]        s_r;
  logic                            dir_r;
  logic signed [PROD_W-1:0]        prod_r;
  logic [te_pkg::RATIO_W-1:0]      ratio_r;
  logic signed [21:0]              gain_r;
  logic signed [SAMPLE_BITS-1:0]   y_r;
  logic                            hit_r;
  logic [31:0]                     count_r;
  logic                            out_valid_r;
  logic [SAMPLE_BITS-1:0]          y_out_r;
  logic                            enh_out_r;
  logic [31:0]                     cnt_out_r;

  logic [te_pkg::CH_W-1:0]         in_ch;
  logic [AW-1:0]                   in_addr;
  logic                            in_range;
  logic                            in_acc;
  logic                            cfg_we;
  logic [SAMPLE_BITS-1:0]          abs_x;
  logic [te_pkg::ENV_W-1:0]        mag;
  logic [te_pkg::ENV_W-1:0]        env_f;
  logic [te_pkg::ENV_W-1:0]        env_s;
  logic [te_pkg::ENV_W-1:0]        diff_f;
  logic [te_pkg::ENV_W-1:0]        diff_s;
  logic                            dir_nxt;
  logic signed [32:0]              mul_a;
  logic signed [24:0]              mul_b;
  logic [PROD_W-2:0]               step_sum;
  logic [te_pkg::ENV_W-1:0]        step;
  logic [te_pkg::ENV_W-1:0]        f_nxt;
  logic [te_pkg::ENV_W-1:0]        s_nxt;
  logic signed [PROD_W-1:0]        prod_rnd;
  logic signed [21:0]              gain_nxt;
  logic signed [SAMPLE_BITS-1:0]   y_nxt;
  logic                            detect;
  logic                            out_free;
  te_pkg::div_req_t                div_req;
  te_pkg::div_rsp_t                div_rsp;

  assign in_ch     = in_tdata[SAMPLE_BITS+te_pkg::CH_W-1:SAMPLE_BITS];
  assign in_addr   = AW'(in_ch);
  assign in_range  = 32'(in_ch) < 32'(MAX_CHANNELS);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      te_pkg::REG_FAST: cfg_prdata = 32'(fast_coef_r);
      te_pkg::REG_SLOW: cfg_prdata = 32'(slow_coef_r);
      te_pkg::REG_SENS: cfg_prdata = 32'(sens_r);
      te_pkg::REG_GAIN: cfg_prdata = 32'($unsigned(gain_m1_r));
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_coef_r <= te_pkg::FAST_COEF_RST;
      slow_coef_r <= te_pkg::SLOW_COEF_RST;
      sens_r      <= te_pkg::SENS_RST;
      gain_m1_r   <= te_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        te_pkg::REG_FAST: fast_coef_r <= cfg_pwdata[23:0];
        te_pkg::REG_SLOW: slow_coef_r <= cfg_pwdata[23:0];
        te_pkg::REG_SENS: sens_r      <= cfg_pwdata[19:0];
        te_pkg::REG_GAIN: gain_m1_r   <= $signed(cfg_pwdata[20:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    abs_x  = x_r[SAMPLE_BITS-1] ? (~$unsigned(x_r) + 1'b1) : $unsigned(x_r);
    mag    = te_pkg::ENV_W'(abs_x) << (te_pkg::ENV_W - SAMPLE_BITS);
    env_f  = env_ok_r ? mem_q_r[MEM_W-1:te_pkg::ENV_W] : '0;
    env_s  = env_ok_r ? mem_q_r[te_pkg::ENV_W-1:0] : '0;
    diff_f = (mag >= env_f) ? mag - env_f : env_f - mag;
    diff_s = (mag >= env_s) ? mag - env_s : env_s - mag;
    dir_nxt = (state_r == S_SMUL) ? (mag >= env_s) : (mag >= env_f);

    step_sum = (PROD_W-1)'(prod_r[PROD_W-3:0]) + (PROD_W-1)'(24'h800000);
    step     = step_sum[55:24];
    f_nxt    = dir_r ? env_f + step : env_f - step;
    s_nxt    = dir_r ? env_s + step : env_s - step;

    prod_rnd = (prod_r + PROD_W'(32768)) >>> 16;
    gain_nxt = 22'(prod_rnd) + 22'(te_pkg::ONE_Q16);
    if (prod_rnd > LIM_HI) begin
      y_nxt = SAMPLE_BITS'(LIM_HI);
    end else if (prod_rnd < LIM_LO) begin
      y_nxt = SAMPLE_BITS'(LIM_LO);
    end else begin
      y_nxt = SAMPLE_BITS'(prod_rnd);
    end

    detect = (PROD_W'({f_r, 16'h0000}) > $unsigned(prod_r)) && (s_r > te_pkg::ENV_FLOOR);
  end

  always_comb begin
    case (state_r)
      S_FMUL: begin
        mul_a = $signed(33'(diff_f));
        mul_b = $signed(25'(fast_coef_r));
      end
      S_SMUL: begin
        mul_a = $signed(33'(diff_s));
        mul_b = $signed(25'(slow_coef_r));
      end
      S_DMUL: begin
        mul_a = $signed(33'(s_r));
        mul_b = $signed(25'(sens_r) + 25'(te_pkg::ONE_Q16));
      end
      S_GMUL: begin
        mul_a = 33'(gain_m1_r);
        mul_b = $signed(25'(ratio_r));
      end
      default: begin
        mul_a = 33'(x_r);
        mul_b = 25'(gain_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    dir_r  <= dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SUPD) begin
      mem[addr_r] <= {f_r, s_nxt};
    end
    if (in_acc && in_range) begin
      mem_q_r <= mem[in_addr];
    end
  end

  assign div_req.start = (state_r == S_DCMP) && detect;
  assign div_req.rem   = f_r - s_r;
  assign div_req.den   = f_r;

  te_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x_r       <= $signed(in_tdata[SAMPLE_BITS-1:0]);
            y_r       <= $signed(in_tdata[SAMPLE_BITS-1:0]);
            addr_r    <= in_addr;
            ch_zero_r <= (in_ch == '0);
            env_ok_r  <= in_range && valid_r[in_addr] && !in_tuser;
            hit_r     <= 1'b0;
            if (in_range && in_tuser && in_ch == '0) begin
              count_r <= '0;
            end
            state_r <= in_range ? S_FMUL : S_OUT;
          end
        end
        S_FMUL: state_r <= S_FUPD;
        S_FUPD: begin
          f_r     <= f_nxt;
          state_r <= S_SMUL;
        end
        S_SMUL: state_r <= S_SUPD;
        S_SUPD: begin
          s_r             <= s_nxt;
          valid_r[addr_r] <= 1'b1;
          state_r         <= S_DMUL;
        end
        S_DMUL: state_r <= S_DCMP;
        S_DCMP: begin
          if (detect) begin
            hit_r <= 1'b1;
            if (ch_zero_r && count_r != '1) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            ratio_r <= div_rsp.quot;
            state_r <= S_GMUL;
          end
        end
        S_GMUL: state_r <= S_GRND;
        S_GRND: begin
          gain_r  <= gain_nxt;
          state_r <= S_YMUL;
        end
        S_YMUL: state_r <= S_YRND;
        S_YRND: begin
          y_r     <= y_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            y_out_r     <= $unsigned(y_r);
            enh_out_r   <= hit_r;
            cnt_out_r   <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({cnt_out_r, y_out_r});
  assign out_tuser  = enh_out_r;

`ifndef ASSERT_OFF
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result word loaded outside the output step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("ratio divider finished while not awaited");

  a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r < $past(count_r)) |->
      $past(in_acc && in_tuser && in_range && in_ch == '0))
    else $error("transient count fell without a channel 0 restart");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second word taken while a sample is in flight");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/te_div.sv =====
`default_nettype none

module te_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire te_pkg::div_req_t req,
  output te_pkg::div_rsp_t      rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [te_pkg::DIVCNT_W-1:0]     cnt_r;
  logic [te_pkg::ENV_W-1:0]        rem_r;
  logic [te_pkg::ENV_W-1:0]        den_r;
  logic [te_pkg::RATIO_W-1:0]      quot_r;
  logic [te_pkg::ENV_W:0]          rem2;
  logic                            ge;
  logic [te_pkg::ENV_W-1:0]        rem_nxt;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = rem2 >= {1'b0, den_r};
    rem_nxt = ge ? te_pkg::ENV_W'(rem2 - {1'b0, den_r}) : te_pkg::ENV_W'(rem2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= req.rem;
        den_r  <= req.den;
        cnt_r  <= te_pkg::DIVCNT_W'(te_pkg::RATIO_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[te_pkg::RATIO_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [23:0] smp;
    logic        hit;
    logic [31:0] count;
  } enhanced_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // sample_in [23:0], channel_index [26:24], zero fill [31:27]
  logic [31:0] in_tdata;
  // restart
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // sample_out [23:0], transient_count [55:24]
  logic [55:0] out_tdata;
  // enhanced
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [23:0]        fast_k = te_pkg::FAST_COEF_RST;
  logic [23:0]        slow_k = te_pkg::SLOW_COEF_RST;
  logic [19:0]        sens   = te_pkg::SENS_RST;
  logic signed [20:0] boost  = te_pkg::GAIN_RST;
  bit   [31:0]        fast_trk [8];
  bit   [31:0]        slow_trk [8];
  bit   [31:0]        ch0_count;

  enhanced_word_t pending_words[$];
  int mismatches;
  int cycles;
  int gap_pct;
  int stall_pct;

  transient_enhancer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch %s: got %0h want %0h", what, got, want);
    end
  endtask

  function automatic bit [31:0] track(bit [31:0] env, bit [31:0] mag, bit [23:0] k);
    bit [63:0] step;
    if (mag >= env) begin
      step = (64'(k) * 64'(mag - env) + 64'h800000) >> 24;
      return env + step[31:0];
    end
    step = (64'(k) * 64'(env - mag) + 64'h800000) >> 24;
    return env - step[31:0];
  endfunction

  function automatic longint q16_round(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic enhanced_word_t shape_sample(logic [23:0] raw, logic [2:0] ch,
                                                  logic rst);
    enhanced_word_t res;
    longint         x;
    longint         y;
    longint         ratio;
    longint         gain;
    bit [31:0]      mag;
    bit [31:0]      f;
    bit [31:0]      s;
    bit [63:0]      quo;
    x = $signed(raw);
    y = x;
    res.hit = 1'b0;
    if (rst) begin
      fast_trk[ch] = '0;
      slow_trk[ch] = '0;
      if (ch == 3'd0) ch0_count = '0;
    end
    mag = 32'((x < 0 ? -x : x) << 8);
    f = track(fast_trk[ch], mag, fast_k);
    s = track(slow_trk[ch], mag, slow_k);
    fast_trk[ch] = f;
    slow_trk[ch] = s;
    if ((64'(f) << 16) > 64'(s) * (64'd65536 + 64'(sens)) && s > te_pkg::ENV_FLOOR) begin
      quo   = (64'(f - s) << 16) / 64'(f);
      ratio = longint'(quo);
      gain  = 65536 + q16_round(longint'(boost) * ratio);
      y     = q16_round(x * gain);
      if (y > 64'sd8388607) y = 64'sd8388607;
      if (y < -64'sd8388608) y = -64'sd8388608;
      res.hit = 1'b1;
      if (ch == 3'd0 && ch0_count != 32'hFFFFFFFF) ch0_count++;
    end
    res.smp   = y[23:0];
    res.count = ch0_count;
    return res;
  endfunction

  always @(posedge clk) begin : check_words
    enhanced_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with none pending", longint'(out_tdata), 0);
      end else begin
        want = pending_words.pop_front();
        if (out_tdata[23:0] !== want.smp)
          report_mismatch("sample_out", out_tdata[23:0], want.smp);
        if (out_tuser !== want.hit)
          report_mismatch("enhanced", out_tuser, want.hit);
        if (out_tdata[55:24] !== want.count)
          report_mismatch("transient_count", out_tdata[55:24], want.count);
      end
    end
  end

  task automatic send_sample(logic [23:0] smp, logic [2:0] ch, logic rst);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, ch, smp};
    in_tuser  <= rst;
    do @(posedge clk); while (!in_tready);
    pending_words.push_back(shape_sample(smp, ch, rst));
  endtask

  // drop valid and wait until every word is back
  task automatic hold_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic check_reg(logic [1:0] idx);
    logic [31:0] data;
    logic [31:0] want;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      te_pkg::REG_FAST: begin
        want = 32'(fast_k);
        data = data & 32'hFFFFFF;
      end
      te_pkg::REG_SLOW: begin
        want = 32'(slow_k);
        data = data & 32'hFFFFFF;
      end
      te_pkg::REG_SENS: begin
        want = 32'(sens);
        data = data & 32'hFFFFF;
      end
      default: begin
        want = 32'(unsigned'(boost));
        data = data & 32'h1FFFFF;
      end
    endcase
    if (data !== want) report_mismatch("register readback", data, want);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      te_pkg::REG_FAST: fast_k = value[23:0];
      te_pkg::REG_SLOW: slow_k = value[23:0];
      te_pkg::REG_SENS: sens   = value[19:0];
      default:          boost  = value[20:0];
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    check_reg(idx);
  endtask

  task automatic apply_setting(int k);
    int fk;
    int sk;
    int sv;
    int gv;
    case (k)
      0: begin
        fk = te_pkg::FAST_COEF_RST; sk = te_pkg::SLOW_COEF_RST; sv = te_pkg::SENS_RST;
        gv = 65536;
      end
      1: begin
        fk = 24'hFFFFFF; sk = 24'hFFFFFF; sv = 0; gv = 1048575;
      end
      2: begin
        fk = 0; sk = 0; sv = 20'hFFFFF; gv = -65536;
      end
      3: begin
        fk = $urandom_range(24'hFFFFFF, 1000000);
        sk = $urandom_range(200000, 1000);
        sv = $urandom_range(65536);
        gv = int'($urandom_range(1114111)) - 65536;
      end
      4: begin
        fk = 24'hFFFFFF; sk = $urandom_range(20000, 2000); sv = 0; gv = -65536;
      end
      default: begin
        fk = $urandom_range(24'hFFFFFF);
        sk = $urandom_range(24'hFFFFFF);
        sv = $urandom_range(20'hFFFFF);
        gv = int'($urandom_range(1114111)) - 65536;
      end
    endcase
    write_reg(te_pkg::REG_FAST, 32'(fk));
    write_reg(te_pkg::REG_SLOW, 32'(sk));
    write_reg(te_pkg::REG_SENS, 32'(sv));
    write_reg(te_pkg::REG_GAIN, 32'(gv));
  endtask

  task automatic test_register_defaults();
    check_reg(te_pkg::REG_FAST);
    check_reg(te_pkg::REG_SLOW);
    check_reg(te_pkg::REG_SENS);
    check_reg(te_pkg::REG_GAIN);
  endtask

  task automatic test_directed_cases();
    // full boost, no margin: full-scale attacks saturate
    write_reg(te_pkg::REG_GAIN, 32'd1048575);
    write_reg(te_pkg::REG_SENS, 32'd0);
    send_sample(24'h7FFFFF, 3'd0, 1'b1);
    send_sample(24'h800000, 3'd0, 1'b0);
    send_sample(24'h000000, 3'd0, 1'b0);
    send_sample(24'h000001, 3'd0, 1'b0);
    send_sample(24'hFFFFFF, 3'd0, 1'b0);
    send_sample(24'h7FFFFF, 3'd7, 1'b1);
    send_sample(24'h800000, 3'd5, 1'b1);
    send_sample(24'd123456, 3'd0, 1'b1);
    send_sample(24'h7FFFFF, 3'd0, 1'b0);
    hold_input();
    // negative boost, widest margin
    write_reg(te_pkg::REG_GAIN, 32'hFFFF0000);
    write_reg(te_pkg::REG_SENS, 32'h000FFFFF);
    send_sample(24'h7FFFFF, 3'd3, 1'b1);
    send_sample(24'h800000, 3'd3, 1'b0);
    send_sample(24'd4000000, 3'd4, 1'b1);
    hold_input();
    // slow follower frozen at zero: never above the floor
    write_reg(te_pkg::REG_FAST, 32'hFFFFFF);
    write_reg(te_pkg::REG_SLOW, 32'd0);
    send_sample(24'h7FFFFF, 3'd2, 1'b1);
    send_sample(24'h800000, 3'd2, 1'b0);
    hold_input();
    // both followers track instantly
    write_reg(te_pkg::REG_SLOW, 32'hFFFFFF);
    send_sample(24'h7FFFFF, 3'd6, 1'b1);
    send_sample(24'h000010, 3'd6, 1'b0);
    hold_input();
    // unity gain still flags the transient
    write_reg(te_pkg::REG_FAST, 32'(te_pkg::FAST_COEF_RST));
    write_reg(te_pkg::REG_SLOW, 32'(te_pkg::SLOW_COEF_RST));
    write_reg(te_pkg::REG_GAIN, 32'd0);
    send_sample(24'h7FFFFF, 3'd1, 1'b1);
    hold_input();
  endtask

  task automatic test_stream_phase(int send_gap, int recv_stall, int setting);
    int          sent;
    int          first;
    int          lanes;
    int          frames;
    int          attack;
    int          quiet;
    int          loud;
    int          amp;
    logic [23:0] smp;
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    for (int k = setting; k < setting + 2; k++) begin
      hold_input();
      apply_setting(k);
      sent = 0;
      while (sent < 160) begin
        if ($urandom_range(9) == 0) begin
          send_sample(24'($urandom), 3'($urandom_range(7)), 1'($urandom_range(1)));
          sent++;
        end else begin
          first  = $urandom_range(7);
          lanes  = $urandom_range(3, 1);
          frames = $urandom_range(40, 4);
          attack = $urandom_range(frames - 1);
          quiet  = $urandom_range(1 << $urandom_range(16));
          loud   = $urandom_range(8388607, 1 << 20);
          for (int n = 0; n < frames; n++) begin
            for (int c = 0; c < lanes; c++) begin
              amp = (n >= attack) ? loud : quiet;
              case ($urandom_range(15))
                0: smp = 24'h800000;
                1: smp = 24'h7FFFFF;
                default: smp = $urandom_range(1) ? -24'($urandom_range(amp))
                                                 : 24'($urandom_range(amp));
              endcase
              send_sample(smp, 3'(first + c), n == 0);
              sent++;
            end
          end
          if ($urandom_range(7) == 0) hold_input();
        end
      end
    end
    hold_input();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_directed_cases();
    test_stream_phase(22, 55, 0);
    test_stream_phase(55, 22, 2);
    test_stream_phase(0, 0, 4);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
